// ===== sv/calendar_date_stepper_top_macros.svh =====
// Assertion macros for the calendar date stepper.
// Used by calendar_date_stepper_top; the macros assume a clock named clk and a reset named rst.
`ifndef CALENDAR_DATE_STEPPER_TOP_MACROS_SVH
`define CALENDAR_DATE_STEPPER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CDS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CDS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/cds_pkg.sv =====
// Shared types, operation codes and calendar helper functions for the date stepper.
// No dependencies; used by cds_day_step and calendar_date_stepper_top.
`default_nettype none

package cds_pkg;

  // Field widths of a date.
  localparam int YearW  = 14;
  localparam int MonthW = 4;
  localparam int DayW   = 5;

  // Operation codes carried on the input tuser.
  localparam logic [2:0] FN_NEXT_DAY  = 3'd0;
  localparam logic [2:0] FN_PREV_DAY  = 3'd1;
  localparam logic [2:0] FN_NEXT_WORK = 3'd2;
  localparam logic [2:0] FN_PREV_WORK = 3'd3;
  localparam logic [2:0] FN_WEEKDAY   = 3'd4;

  // Year range and the Julian/Gregorian switch year.
  localparam logic [YearW-1:0] YearMin    = 14'd1;
  localparam logic [YearW-1:0] YearMax    = 14'd9999;
  localparam logic [YearW-1:0] SwitchYear = 14'd1752;

  // Weekday codes of the weekend.
  localparam logic [2:0] WD_SATURDAY = 3'd6;
  localparam logic [2:0] WD_SUNDAY   = 3'd7;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
  } date_t;

  // Month length; zero for a month outside 1..12.
  function automatic logic [DayW-1:0] days_in(input logic [MonthW-1:0] m, input logic leap);
    logic [DayW-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // The term (3 * (m + 1)) / 5 of the weekday sum for shifted months 3..14.
  function automatic logic [3:0] month_term(input logic [MonthW-1:0] mm);
    logic [3:0] t;
    case (mm)
      4'd3:           t = 4'd2;
      4'd4, 4'd5:     t = 4'd3;
      4'd6, 4'd7:     t = 4'd4;
      4'd8:           t = 4'd5;
      4'd9, 4'd10:    t = 4'd6;
      4'd11, 4'd12:   t = 4'd7;
      4'd13:          t = 4'd8;
      4'd14:          t = 4'd9;
      default:        t = 4'd0;
    endcase
    return t;
  endfunction

  // Remainder modulo 7 by folding octal digits (8 is 1 modulo 7).
  function automatic logic [2:0] mod7(input logic [14:0] v);
    logic [5:0] a;
    logic [3:0] b;
    logic [3:0] c;
    a = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9]) + 6'(v[14:12]);
    b = 4'(a[2:0]) + 4'(a[5:3]);
    c = 4'(b[2:0]) + 4'(b[3]);
    if (c >= 4'd7) begin
      c = c - 4'd7;
    end
    return c[2:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/cds_day_step.sv =====
// One-day step unit of the date stepper: moves a date one day forward or back.
// Depends on cds_pkg for the date type, the year range and month lengths.
`default_nettype none

module cds_day_step (
  input  var cds_pkg::date_t cur,    // date before the step
  input  var logic           leap,   // leap flag of the year whose February may be read
  input  var logic           back,   // 1 steps back, 0 steps forward
  output cds_pkg::date_t     nxt,    // date after the step
  output logic               ok      // 0 when the year would leave its range
);

  logic [cds_pkg::DayW-1:0]   len_cur;
  logic [cds_pkg::DayW-1:0]   len_prev;
  logic [cds_pkg::MonthW-1:0] month_prev;

  // Lengths of the current and of the previous month.
  assign month_prev = cur.month - 4'd1;
  assign len_cur    = cds_pkg::days_in(cur.month, leap);
  assign len_prev   = cds_pkg::days_in(month_prev, leap);

  // Roll the day, then the month, then the year.
  always_comb begin
    nxt = cur;
    ok  = 1'b1;
    if (!back) begin
      if (cur.day < len_cur) begin
        nxt.day = cur.day + 5'd1;
      end else if (cur.month < 4'd12) begin
        nxt.month = cur.month + 4'd1;
        nxt.day   = 5'd1;
      end else if (cur.year >= cds_pkg::YearMax) begin
        ok = 1'b0;
      end else begin
        nxt.year  = cur.year + 14'd1;
        nxt.month = 4'd1;
        nxt.day   = 5'd1;
      end
    end else begin
      if (cur.day > 5'd1) begin
        nxt.day = cur.day - 5'd1;
      end else if (cur.month > 4'd1) begin
        nxt.month = month_prev;
        nxt.day   = len_prev;
      end else if (cur.year <= cds_pkg::YearMin) begin
        ok = 1'b0;
      end else begin
        nxt.year  = cur.year - 14'd1;
        nxt.month = 4'd12;
        nxt.day   = 5'd31;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/calendar_date_stepper_top.sv =====
// Top level of the calendar date stepper: sequencer, shared divide-by-100 unit and weekday sum.
// Depends on cds_pkg, cds_day_step and calendar_date_stepper_top_macros.svh.
//
//  Channel   Direction  Signals                      Content
//  s_*       in         tvalid/tready/tdata/tuser    date and operation code
//  m_*       out        tvalid/tready/tdata/tuser    resulting date, weekday, error flag
//
// One transaction is worked on at a time; s_tready is high only while the block is idle.
// An accepted request passes ST_LEAP and ST_CHECK; an illegal input then goes to ST_DONE,
// a weekday request through ST_WDIV, ST_WSUM and ST_WMOD, and a day step through ST_STEP
// first; a working-day step that lands on a weekend takes up to two extra day steps and
// a second weekday pass. A single day step unit and a single divide-by-100 multiplier serve them.
// A finished result holds on m_* until m_tready; rst is synchronous and returns to idle.
`default_nettype none
`include "calendar_date_stepper_top_macros.svh"

module calendar_date_stepper_top (
  input  var logic        clk,
  input  var logic        rst,
  input  var logic        s_tvalid,
  output logic            s_tready,
  input  var logic [23:0] s_tdata,   // year_in[13:0], month_in[17:14], day_in[22:18], zero pad
  input  var logic [2:0]  s_tuser,   // func[2:0]
  output logic            m_tvalid,
  input  var logic        m_tready,
  output logic [31:0]     m_tdata,   // year_out[13:0], month_out[17:14], day_out[22:18],
                                     // weekday[25:23], zero pad
  output logic [0:0]      m_tuser    // bad_date[0]
);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_LEAP  = 8'b0000_0010,
    ST_CHECK = 8'b0000_0100,
    ST_STEP  = 8'b0000_1000,
    ST_WDIV  = 8'b0001_0000,
    ST_WSUM  = 8'b0010_0000,
    ST_WMOD  = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_t;

  state_t          state;
  logic [2:0]      func_r;
  cds_pkg::date_t  din_r;
  cds_pkg::date_t  cur;
  logic [7:0]      q_r;
  logic            leap_r;
  logic [14:0]     s_r;
  logic [2:0]      weekday_r;
  logic            bad_r;
  logic [1:0]      steps_left;
  logic            skip_done;

  logic            s_hs;
  logic            m_hs;
  logic            back;
  logic            workday;

  // Shared divide-by-100 unit: multiply by the reciprocal 5243 / 2^19.
  logic [13:0]     div_opnd;
  logic [26:0]     div_prod;
  logic [7:0]      q100;

  // Calendar helpers.
  logic            early_month;
  logic [13:0]     yz;
  logic [3:0]      mm;
  logic [14:0]     q_times_100;
  logic            leap_now;
  logic            date_ok;
  logic [14:0]     s_base;
  logic            julian;
  logic [2:0]      wd;
  logic [1:0]      extra;

  cds_pkg::date_t  step_nxt;
  logic            step_ok;

  assign s_hs    = s_tvalid && s_tready;
  assign m_hs    = m_tvalid && m_tready;
  assign back    = (func_r == cds_pkg::FN_PREV_DAY) || (func_r == cds_pkg::FN_PREV_WORK);
  assign workday = (func_r == cds_pkg::FN_NEXT_WORK) || (func_r == cds_pkg::FN_PREV_WORK);

  // January and February count as months 13 and 14 of the year before.
  assign early_month = (cur.month <= 4'd2);
  assign yz          = early_month ? (cur.year - 14'd1) : cur.year;
  assign mm          = early_month ? (cur.month + 4'd12) : cur.month;

  // The divider serves the leap test of the input year and the weekday sum.
  assign div_opnd = (state == ST_LEAP) ? cur.year : yz;
  assign div_prod = 27'(div_opnd) * 27'd5243;
  assign q100     = div_prod[26:19];

  // Leap test of the current year from its quotient by 100.
  assign q_times_100 = (15'(q_r) << 6) + (15'(q_r) << 5) + (15'(q_r) << 2);
  assign leap_now    = (cur.year[1:0] == 2'b00) &&
                       ((q_times_100 != 15'(cur.year)) || (q_r[1:0] == 2'b00));

  // Legality of the accepted transaction.
  assign date_ok = (func_r <= cds_pkg::FN_WEEKDAY) &&
                   (cur.year >= cds_pkg::YearMin) && (cur.year <= cds_pkg::YearMax) &&
                   (cur.month >= 4'd1) && (cur.month <= 4'd12) &&
                   (cur.day >= 5'd1) && (cur.day <= cds_pkg::days_in(cur.month, leap_now));

  // Weekday sum before the calendar correction.
  assign s_base = 15'(cur.day) + (15'(mm) << 1) + 15'(cds_pkg::month_term(mm)) +
                  15'(yz) + 15'(yz >> 2);
  assign julian = (yz < cds_pkg::SwitchYear) ||
                  ((yz == cds_pkg::SwitchYear) && (mm < 4'd9)) ||
                  ((yz == cds_pkg::SwitchYear) && (mm == 4'd9) && (cur.day < 5'd3));

  // Weekday and the number of days needed to leave a weekend.
  assign wd = cds_pkg::mod7(s_r) + 3'd1;
  always_comb begin
    extra = 2'd0;
    if (wd == cds_pkg::WD_SATURDAY) begin
      extra = back ? 2'd1 : 2'd2;
    end else if (wd == cds_pkg::WD_SUNDAY) begin
      extra = back ? 2'd2 : 2'd1;
    end
  end

  cds_day_step u_step (
    .cur  (cur),
    .leap (leap_r),
    .back (back),
    .nxt  (step_nxt),
    .ok   (step_ok)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      bad_r      <= 1'b0;
      steps_left <= 2'd0;
      skip_done  <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_hs) begin
            bad_r      <= 1'b0;
            skip_done  <= 1'b0;
            steps_left <= 2'd0;
            state      <= ST_LEAP;
          end
        end
        ST_LEAP: begin
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          if (!date_ok) begin
            bad_r <= 1'b1;
            state <= ST_DONE;
          end else if (func_r == cds_pkg::FN_WEEKDAY) begin
            state <= ST_WDIV;
          end else begin
            steps_left <= 2'd1;
            state      <= ST_STEP;
          end
        end
        ST_STEP: begin
          if (!step_ok) begin
            bad_r <= 1'b1;
            state <= ST_DONE;
          end else begin
            steps_left <= steps_left - 2'd1;
            state      <= (steps_left == 2'd1) ? ST_WDIV : ST_STEP;
          end
        end
        ST_WDIV: begin
          state <= ST_WSUM;
        end
        ST_WSUM: begin
          state <= ST_WMOD;
        end
        ST_WMOD: begin
          if (workday && !skip_done && (extra != 2'd0)) begin
            skip_done  <= 1'b1;
            steps_left <= extra;
            state      <= ST_STEP;
          end else begin
            skip_done <= 1'b1;
            state     <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (m_hs) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && s_hs) begin
      func_r      <= s_tuser;
      din_r.year  <= s_tdata[13:0];
      din_r.month <= s_tdata[17:14];
      din_r.day   <= s_tdata[22:18];
      cur.year    <= s_tdata[13:0];
      cur.month   <= s_tdata[17:14];
      cur.day     <= s_tdata[22:18];
    end
    if ((state == ST_LEAP) || (state == ST_WDIV)) begin
      q_r <= q100;
    end
    if (state == ST_CHECK) begin
      leap_r <= leap_now;
    end
    if ((state == ST_STEP) && step_ok) begin
      cur <= step_nxt;
    end
    if (state == ST_WSUM) begin
      s_r <= julian ? (s_base + 15'd5)
                    : (s_base + 15'(q_r >> 2) - 15'(q_r));
    end
    if (state == ST_WMOD) begin
      weekday_r <= wd;
    end
  end

  // Output channel: an illegal request echoes the input date with weekday zero.
  assign s_tready   = (state == ST_IDLE);
  assign m_tvalid   = (state == ST_DONE);
  assign m_tdata    = bad_r ? {9'd0, din_r.day, din_r.month, din_r.year}
                            : {6'd0, weekday_r, cur.day, cur.month, cur.year};
  assign m_tuser[0] = bad_r;

  `CDS_ASSERT_SAME(a_one_in_flight, m_tvalid, !s_tready, "result pending while ready")
  `CDS_ASSERT_NEXT(a_accept_starts, s_hs, state == ST_LEAP, "accept did not start the sequence")
  `CDS_ASSERT_SAME(a_step_count, state == ST_STEP, steps_left != 2'd0, "step with no steps left")
  `CDS_ASSERT_SAME(a_weekday_set, m_tvalid && !bad_r, weekday_r != 3'd0,
                   "good result without a weekday")
  `CDS_ASSERT_NEXT(a_result_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
                   "stalled result changed")

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for calendar_date_stepper_top: directed table, then random dates.
// Depends on cds_pkg for operation codes, weekday codes and the year range; predicts every result not carried inline.
`default_nettype none

module testbench;

  // Operation codes outside the defined set.
  localparam logic [2:0] FN_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] FN_LAST_UNUSED  = 3'd7;

  // Year bounds and the calendar switch as plain integers for the predictor.
  localparam int unsigned FirstYear  = 32'(cds_pkg::YearMin);
  localparam int unsigned LastYear   = 32'(cds_pkg::YearMax);
  localparam int unsigned ReformYear = 32'(cds_pkg::SwitchYear);

  localparam int RandomItems = 1450;
  localparam int QuietTail   = 200;
  localparam int LongHold    = 300;
  localparam int CycleLimit  = 400000;
  localparam int PlanRows    = 25;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [2:0]  weekday;
    logic        bad;
  } date_result_t;

  typedef struct packed {
    logic [2:0]   fn;
    logic [13:0]  year;
    logic [3:0]   month;
    logic [4:0]   day;
    logic         typed;
    date_result_t want;
  } date_row_t;

  typedef struct {
    int unsigned y;
    int unsigned m;
    int unsigned d;
  } cal_day_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [0:0]  m_tuser;

  date_result_t awaited_dates[$];
  date_result_t oldest_date;
  date_row_t    plan [PlanRows];
  int           fault_count = 0;
  int           cycle_count = 0;
  bit           idle_on = 1'b1;
  bit           hold_sink = 1'b0;

  calendar_date_stepper_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Clock with a period of two time units.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Gregorian leap rule, used for month lengths in every era.
  function automatic bit leap_year(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_days(int unsigned y, int unsigned m);
    int unsigned len;
    case (m)
      1, 3, 5, 7, 8, 10, 12: len = 31;
      4, 6, 9, 11:           len = 30;
      2:                     len = leap_year(y) ? 29 : 28;
      default:               len = 0;
    endcase
    return len;
  endfunction

  // Zeller-style weekday, 1 Monday to 7 Sunday; Julian sum before the 1752 switch.
  function automatic logic [2:0] weekday_of(int unsigned y, int unsigned m, int unsigned d);
    int unsigned s;
    if (m <= 2) begin
      m = m + 12;
      y = y - 1;
    end
    s = d + 2 * m + (3 * (m + 1)) / 5 + y + y / 4;
    if (y < ReformYear || (y == ReformYear && m < 9) ||
        (y == ReformYear && m == 9 && d < 3)) begin
      return 3'(1 + (s + 5) % 7);
    end
    return 3'(1 + (s + y / 400 - y / 100) % 7);
  endfunction

  // One day forward; zero when the year would pass the top of the range.
  function automatic bit step_forward(inout cal_day_t dt);
    if (dt.d < month_days(dt.y, dt.m)) begin
      dt.d = dt.d + 1;
      return 1'b1;
    end
    if (dt.m < 12) begin
      dt.m = dt.m + 1;
      dt.d = 1;
      return 1'b1;
    end
    if (dt.y >= LastYear) begin
      return 1'b0;
    end
    dt.y = dt.y + 1;
    dt.m = 1;
    dt.d = 1;
    return 1'b1;
  endfunction

  // One day back; zero when the year would fall below the range.
  function automatic bit step_backward(inout cal_day_t dt);
    if (dt.d > 1) begin
      dt.d = dt.d - 1;
      return 1'b1;
    end
    if (dt.m > 1) begin
      dt.m = dt.m - 1;
      dt.d = month_days(dt.y, dt.m);
      return 1'b1;
    end
    if (dt.y <= FirstYear) begin
      return 1'b0;
    end
    dt.y = dt.y - 1;
    dt.m = 12;
    dt.d = 31;
    return 1'b1;
  endfunction

  // Expected answer for one request.
  function automatic date_result_t predict_date(logic [2:0] fn, logic [13:0] yi,
                                                logic [3:0] mi, logic [4:0] di);
    date_result_t r;
    cal_day_t     dt;
    int unsigned  extra;
    int unsigned  i;
    logic [2:0]   wd;
    bit           ok;
    bit           fwd;
    dt.y = 32'(yi);
    dt.m = 32'(mi);
    dt.d = 32'(di);
    fwd = (fn == cds_pkg::FN_NEXT_DAY) || (fn == cds_pkg::FN_NEXT_WORK);
    ok = !(fn > cds_pkg::FN_WEEKDAY || dt.y < FirstYear || dt.y > LastYear || dt.m < 1 ||
           dt.m > 12 || dt.d < 1 || dt.d > month_days(dt.y, dt.m));
    if (ok && fn != cds_pkg::FN_WEEKDAY) begin
      ok = fwd ? step_forward(dt) : step_backward(dt);
    end
    // Working-day forms skip the weekend with up to two more steps.
    if (ok && (fn == cds_pkg::FN_NEXT_WORK || fn == cds_pkg::FN_PREV_WORK)) begin
      wd = weekday_of(dt.y, dt.m, dt.d);
      extra = 0;
      if (wd == cds_pkg::WD_SATURDAY) begin
        extra = fwd ? 2 : 1;
      end else if (wd == cds_pkg::WD_SUNDAY) begin
        extra = fwd ? 1 : 2;
      end
      for (i = 0; i < extra && ok; i++) begin
        ok = fwd ? step_forward(dt) : step_backward(dt);
      end
    end
    if (ok) begin
      r.year    = 14'(dt.y);
      r.month   = 4'(dt.m);
      r.day     = 5'(dt.d);
      r.weekday = weekday_of(dt.y, dt.m, dt.d);
      r.bad     = 1'b0;
    end else begin
      r.year    = yi;
      r.month   = mi;
      r.day     = di;
      r.weekday = 3'd0;
      r.bad     = 1'b1;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fault_count++;
    end
  endtask

  // Offer one request and hold it until it is accepted.
  task automatic send_date(input logic [2:0] fn, input logic [13:0] y, input logic [3:0] m,
                           input logic [4:0] d, input logic typed, input date_result_t want);
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, d, m, y};
    s_tuser  <= fn;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    awaited_dates.push_back(typed ? want : predict_date(fn, y, m, d));
  endtask

  task automatic idle_gap(input int n);
    s_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Stop offering until every pending result has arrived.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (awaited_dates.size() != 0) @(posedge clk);
  endtask

  // A legal date, weighted toward range ends, the calendar switch and month ends.
  task automatic rand_legal(output logic [13:0] y, output logic [3:0] m, output logic [4:0] d);
    int unsigned len;
    case ($urandom_range(0, 9))
      0: y = $urandom_range(0, 1) ? cds_pkg::YearMax : cds_pkg::YearMin;
      1: y = $urandom_range(0, 1) ? cds_pkg::SwitchYear : cds_pkg::SwitchYear + 14'd1;
      2: y = 14'($urandom_range(16, 24) * 100);
      default: y = 14'($urandom_range(1, 9999));
    endcase
    m = (y == cds_pkg::SwitchYear && $urandom_range(0, 1)) ? 4'd9 : 4'($urandom_range(1, 12));
    len = month_days(32'(y), 32'(m));
    case ($urandom_range(0, 5))
      0: d = 5'd1;
      1: d = 5'(len);
      2: d = 5'($urandom_range(len - 2, len));
      3: d = 5'($urandom_range(1, 5));
      default: d = 5'($urandom_range(1, len));
    endcase
  endtask

  // Directed rows; bad requests and well-known weekdays carry their answer inline.
  initial begin
    plan[0]  = '{cds_pkg::FN_WEEKDAY, 14'd2000, 4'd1, 5'd1, 1'b1,
                 '{14'd2000, 4'd1, 5'd1, 3'd6, 1'b0}};
    plan[1]  = '{cds_pkg::FN_NEXT_DAY, 14'd1999, 4'd12, 5'd31, 1'b1,
                 '{14'd2000, 4'd1, 5'd1, 3'd6, 1'b0}};
    plan[2]  = '{cds_pkg::FN_WEEKDAY, 14'd1752, 4'd9, 5'd2, 1'b1,
                 '{14'd1752, 4'd9, 5'd2, 3'd3, 1'b0}};
    plan[3]  = '{cds_pkg::FN_WEEKDAY, 14'd1752, 4'd9, 5'd14, 1'b1,
                 '{14'd1752, 4'd9, 5'd14, 3'd4, 1'b0}};
    plan[4]  = '{cds_pkg::FN_NEXT_DAY, 14'd1752, 4'd9, 5'd2, 1'b0, '0};
    plan[5]  = '{cds_pkg::FN_NEXT_DAY, 14'd9999, 4'd12, 5'd31, 1'b1,
                 '{14'd9999, 4'd12, 5'd31, 3'd0, 1'b1}};
    plan[6]  = '{cds_pkg::FN_PREV_DAY, 14'd1, 4'd1, 5'd1, 1'b1,
                 '{14'd1, 4'd1, 5'd1, 3'd0, 1'b1}};
    plan[7]  = '{cds_pkg::FN_NEXT_WORK, 14'd9999, 4'd12, 5'd31, 1'b1,
                 '{14'd9999, 4'd12, 5'd31, 3'd0, 1'b1}};
    plan[8]  = '{cds_pkg::FN_PREV_WORK, 14'd1, 4'd1, 5'd1, 1'b1,
                 '{14'd1, 4'd1, 5'd1, 3'd0, 1'b1}};
    plan[9]  = '{cds_pkg::FN_WEEKDAY, 14'd1, 4'd1, 5'd1, 1'b0, '0};
    plan[10] = '{cds_pkg::FN_PREV_WORK, 14'd1, 4'd1, 5'd3, 1'b0, '0};
    plan[11] = '{cds_pkg::FN_NEXT_WORK, 14'd9999, 4'd12, 5'd30, 1'b0, '0};
    plan[12] = '{cds_pkg::FN_NEXT_DAY, 14'd0, 4'd1, 5'd1, 1'b1,
                 '{14'd0, 4'd1, 5'd1, 3'd0, 1'b1}};
    plan[13] = '{cds_pkg::FN_WEEKDAY, 14'd16383, 4'd15, 5'd31, 1'b1,
                 '{14'd16383, 4'd15, 5'd31, 3'd0, 1'b1}};
    plan[14] = '{cds_pkg::FN_PREV_DAY, 14'd2001, 4'd0, 5'd10, 1'b1,
                 '{14'd2001, 4'd0, 5'd10, 3'd0, 1'b1}};
    plan[15] = '{cds_pkg::FN_NEXT_DAY, 14'd2001, 4'd13, 5'd10, 1'b1,
                 '{14'd2001, 4'd13, 5'd10, 3'd0, 1'b1}};
    plan[16] = '{cds_pkg::FN_PREV_DAY, 14'd2001, 4'd4, 5'd0, 1'b1,
                 '{14'd2001, 4'd4, 5'd0, 3'd0, 1'b1}};
    plan[17] = '{cds_pkg::FN_NEXT_DAY, 14'd2001, 4'd4, 5'd31, 1'b1,
                 '{14'd2001, 4'd4, 5'd31, 3'd0, 1'b1}};
    plan[18] = '{cds_pkg::FN_NEXT_DAY, 14'd1900, 4'd2, 5'd29, 1'b1,
                 '{14'd1900, 4'd2, 5'd29, 3'd0, 1'b1}};
    plan[19] = '{cds_pkg::FN_NEXT_DAY, 14'd2000, 4'd2, 5'd29, 1'b0, '0};
    plan[20] = '{FN_FIRST_UNUSED, 14'd2000, 4'd1, 5'd1, 1'b1, '{14'd2000, 4'd1, 5'd1, 3'd0, 1'b1}};
    plan[21] = '{FN_LAST_UNUSED, 14'd2000, 4'd1, 5'd1, 1'b1, '{14'd2000, 4'd1, 5'd1, 3'd0, 1'b1}};
    plan[22] = '{cds_pkg::FN_NEXT_WORK, 14'd2000, 4'd1, 5'd8, 1'b0, '0};
    plan[23] = '{cds_pkg::FN_PREV_WORK, 14'd2000, 4'd1, 5'd9, 1'b0, '0};
    plan[24] = '{cds_pkg::FN_PREV_WORK, 14'd2000, 4'd1, 5'd10, 1'b0, '0};
  end

  // Result sink: random stalls, one long hold-off on request, ready otherwise.
  initial begin : result_sink
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_sink) begin
        m_tready <= 1'b0;
        repeat (LongHold) @(posedge clk);
        hold_sink = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Result checker against the oldest pending prediction.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (awaited_dates.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual tdata %h tuser %b",
                 $time, m_tdata, m_tuser);
        fault_count++;
      end else begin
        oldest_date = awaited_dates.pop_front();
        check_field("year_out", 32'(oldest_date.year), 32'(m_tdata[13:0]));
        check_field("month_out", 32'(oldest_date.month), 32'(m_tdata[17:14]));
        check_field("day_out", 32'(oldest_date.day), 32'(m_tdata[22:18]));
        check_field("weekday", 32'(oldest_date.weekday), 32'(m_tdata[25:23]));
        check_field("bad_date", 32'(oldest_date.bad), 32'(m_tuser[0]));
      end
    end
  end

  // Stimulus: directed table, then a weighted random mix.
  initial begin : stimulus
    logic [2:0]  fn;
    logic [13:0] y;
    logic [3:0]  m;
    logic [4:0]  d;
    int unsigned pick;
    int unsigned len;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < PlanRows; i++) begin
      send_date(plan[i].fn, plan[i].year, plan[i].month, plan[i].day,
                plan[i].typed, plan[i].want);
      if ($urandom_range(0, 2) == 0) begin
        idle_gap($urandom_range(1, 16));
      end
    end
    drain_results();

    for (int k = 0; k < RandomItems; k++) begin
      // Idling runs in stretches, and stops for the tail of the run.
      idle_on = (k < RandomItems - QuietTail) && ((k / 100) % 3 != 2);
      if (k == 400) begin
        hold_sink = 1'b1;
      end
      pick = $urandom_range(0, 99);
      rand_legal(y, m, d);
      fn = 3'($urandom_range(0, 4));
      if (pick >= 78 && pick < 85) begin
        fn = 3'($urandom_range(32'(FN_FIRST_UNUSED), 32'(FN_LAST_UNUSED)));
      end else if (pick >= 85 && pick < 93) begin
        // Broken date: day past the month end, day zero or month too large.
        len = month_days(32'(y), 32'(m));
        case ($urandom_range(0, 2))
          0: d = (len < 31) ? 5'($urandom_range(len + 1, 31)) : 5'd0;
          1: d = 5'd0;
          default: m = 4'($urandom_range(13, 15));
        endcase
      end else if (pick >= 93) begin
        fn = 3'($urandom_range(0, 7));
        y  = 14'($urandom_range(0, 16383));
        m  = 4'($urandom_range(0, 15));
        d  = 5'($urandom_range(0, 31));
      end
      send_date(fn, y, m, d, 1'b0, '0);
      if (k == 800) begin
        drain_results();
      end else if (idle_on && !hold_sink && $urandom_range(0, 3) == 0) begin
        idle_gap($urandom_range(1, 16));
      end
    end

    drain_results();
    repeat (30) @(posedge clk);
    if (fault_count == 0 && awaited_dates.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
